// ----- hdl/deq_pkg.sv -----
// Package for the double-ended queue unit: operation codes, status codes,
// the command class carried between the front and back parts, and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

	// Default sizes handed to the top level.
	localparam int DEQ_DEPTH      = 16;
	localparam int DEQ_DATA_WIDTH = 32;

	// Fixed widths of the channel fields.
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes on the request channel.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5
	} deq_op_t;

	// Status codes on the result channel.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} deq_status_t;

	// Class of a command after decoding.
	typedef enum logic [1:0] {
		KIND_NOP  = 2'd0,
		KIND_PUSH = 2'd1,
		KIND_POP  = 2'd2,
		KIND_PEEK = 2'd3
	} deq_kind_t;

	// Control part of a decoded command.
	typedef struct packed {
		deq_kind_t kind;
		logic      at_back;
	} deq_ctl_t;

endpackage

// ----- hdl/deq_in_if.sv -----
// Request channel interface of the double-ended queue unit.
// Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_in_if;
	import deq_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

// ----- hdl/deq_out_if.sv -----
// Result channel interface of the double-ended queue unit.
// Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_out_if;
	import deq_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	modport source (output valid, output data, output status, output count,
		output is_empty, input ready);
	modport sink (input valid, input data, input status, input count,
		input is_empty, output ready);
endinterface

// ----- hdl/deq_front.sv -----
// Front part of the double-ended queue unit: accepts request transactions,
// decodes them into a command class and side, and registers them.
// Depends on deq_pkg and deq_in_if.
`timescale 1ns / 1ps

module deq_front #(
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	deq_in_if.sink                cmd,
	output logic                  q_valid,
	output deq_pkg::deq_ctl_t     q_ctl,
	output logic [DATA_WIDTH-1:0] q_word,
	input  logic                  q_ready
);
	import deq_pkg::*;

	localparam int DW_MIN = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

	logic                  valid_s1;
	deq_ctl_t              ctl_s1;
	logic [DATA_WIDTH-1:0] word_s1;
	deq_ctl_t              ctl_c;
	logic [DATA_WIDTH-1:0] word_c;
	logic                  take;

	// The stage takes a new transaction when it is empty or drains this cycle.
	assign cmd.ready = !valid_s1 || q_ready;
	assign take      = cmd.valid && cmd.ready;

	// Decode the operation code into class and side.
	always_comb begin
		ctl_c = '{kind: KIND_NOP, at_back: 1'b0};
		unique case (deq_op_t'(cmd.operation))
			OP_PUSH_FRONT: ctl_c = '{kind: KIND_PUSH, at_back: 1'b0};
			OP_PUSH_BACK:  ctl_c = '{kind: KIND_PUSH, at_back: 1'b1};
			OP_POP_FRONT:  ctl_c = '{kind: KIND_POP,  at_back: 1'b0};
			OP_POP_BACK:   ctl_c = '{kind: KIND_POP,  at_back: 1'b1};
			OP_PEEK_FRONT: ctl_c = '{kind: KIND_PEEK, at_back: 1'b0};
			OP_PEEK_BACK:  ctl_c = '{kind: KIND_PEEK, at_back: 1'b1};
			default:       ctl_c = '{kind: KIND_NOP,  at_back: 1'b0};
		endcase
	end

	// Only the low bits of the word are stored.
	always_comb begin
		word_c              = '0;
		word_c[DW_MIN-1:0]  = cmd.value[DW_MIN-1:0];
	end

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1  <= ctl_c;
			word_s1 <= word_c;
		end
	end

	assign q_valid = valid_s1;
	assign q_ctl   = ctl_s1;
	assign q_word  = word_s1;

endmodule

// ----- hdl/deq_fifo.sv -----
// Two-entry command queue between the front and back parts of the
// double-ended queue unit. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_fifo #(
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	input  deq_pkg::deq_ctl_t     wr_ctl,
	input  logic [DATA_WIDTH-1:0] wr_word,
	output logic                  wr_ready,
	output logic                  rd_valid,
	output deq_pkg::deq_ctl_t     rd_ctl,
	output logic [DATA_WIDTH-1:0] rd_word,
	input  logic                  rd_ready
);
	import deq_pkg::*;

	deq_ctl_t              ctl_q  [2];
	logic [DATA_WIDTH-1:0] word_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;
	logic                  push;
	logic                  pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_ctl   = ctl_q[rd_ptr_q];
	assign rd_word  = word_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]  <= wr_ctl;
			word_q[wr_ptr_q] <= wr_word;
		end
	end

endmodule

// ----- hdl/deq_back.sv -----
// Back part of the double-ended queue unit: the ring store with its front
// index and element count, and the result register. Depends on deq_pkg, deq_out_if.
`timescale 1ns / 1ps

module deq_back #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  deq_pkg::deq_ctl_t     q_ctl,
	input  logic [DATA_WIDTH-1:0] q_word,
	output logic                  q_ready,
	deq_out_if.source             res
);
	import deq_pkg::*;

	localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW     = IW + 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int DW_MIN = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int CW_MIN = (CW < COUNT_W) ? CW : COUNT_W;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [IW-1:0] LAST_I  = IW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	logic [IW-1:0]         front_q;
	logic [CW-1:0]         count_q;

	logic                  s1_valid;
	deq_status_t           status_s1;
	logic                  use_data_s1;
	logic [CW-1:0]         count_s1;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_data_q;
	deq_status_t           out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_empty_q;

	logic                  adv;
	logic                  take;
	logic                  is_empty;
	logic                  is_full;
	logic [IW-1:0]         front_dec;
	logic [IW-1:0]         front_inc;
	logic [SW-1:0]         sum_back;
	logic [SW-1:0]         sum_last;
	logic [IW-1:0]         back_pos;
	logic [IW-1:0]         last_pos;
	logic [IW-1:0]         rd_addr;
	logic [IW-1:0]         wr_addr;
	logic                  wr_en;
	logic [IW-1:0]         front_nxt;
	logic [CW-1:0]         count_nxt;
	deq_status_t           status_c;
	logic                  use_data_c;
	logic [VALUE_W-1:0]    data_ext;
	logic [COUNT_W-1:0]    count_ext;

	// Handshake: results move out when the output register is free or taken.
	assign adv     = !out_valid_q || res.ready;
	assign q_ready = !s1_valid || adv;
	assign take    = q_valid && q_ready;

	// Ring positions around the front index.
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == DEPTH_C);
	assign front_dec = (front_q == '0) ? LAST_I : front_q - IW'(1);
	assign front_inc = (front_q == LAST_I) ? '0 : front_q + IW'(1);
	assign sum_back  = SW'(front_q) + SW'(count_q);
	assign sum_last  = sum_back - SW'(1);
	assign back_pos  = (sum_back >= DEPTH_S) ? IW'(sum_back - DEPTH_S) : IW'(sum_back);
	assign last_pos  = (sum_last >= DEPTH_S) ? IW'(sum_last - DEPTH_S) : IW'(sum_last);
	assign rd_addr   = q_ctl.at_back ? last_pos : front_q;
	assign wr_addr   = q_ctl.at_back ? back_pos : front_dec;

	// Carry out the command: next index, count, status and store access.
	always_comb begin
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_c   = ST_OK;
		use_data_c = 1'b0;
		wr_en      = 1'b0;
		unique case (q_ctl.kind)
			KIND_PUSH: begin
				if (is_full) begin
					status_c = ST_FULL;
				end else begin
					wr_en     = take;
					count_nxt = count_q + CW'(1);
					if (!q_ctl.at_back) begin
						front_nxt = front_dec;
					end
				end
			end
			KIND_POP: begin
				if (is_empty) begin
					status_c = ST_EMPTY;
				end else begin
					use_data_c = 1'b1;
					count_nxt  = count_q - CW'(1);
					if (!q_ctl.at_back) begin
						front_nxt = front_inc;
					end
				end
			end
			KIND_PEEK: begin
				if (is_empty) begin
					status_c = ST_EMPTY;
				end else begin
					use_data_c = 1'b1;
				end
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	// Ring store with registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= q_word;
		end
		if (take) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Ring state and pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end
			if (q_ready) begin
				s1_valid <= take;
			end
			if (adv) begin
				out_valid_q <= s1_valid;
			end
		end
	end

	// Result fields of the executed command.
	always_ff @(posedge clk) begin
		if (take) begin
			status_s1   <= status_c;
			use_data_s1 <= use_data_c;
			count_s1    <= count_nxt;
		end
	end

	// Resize the stored word and the count to the result fields.
	always_comb begin
		data_ext                 = '0;
		data_ext[DW_MIN-1:0]     = rd_q[DW_MIN-1:0];
		count_ext                = '0;
		count_ext[CW_MIN-1:0]    = count_s1[CW_MIN-1:0];
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			out_data_q   <= use_data_s1 ? data_ext : '0;
			out_status_q <= status_s1;
			out_count_q  <= count_ext;
			out_empty_q  <= (count_s1 == '0);
		end
	end

	assign res.valid    = out_valid_q;
	assign res.data     = out_data_q;
	assign res.status   = out_status_q;
	assign res.count    = out_count_q;
	assign res.is_empty = out_empty_q;

endmodule

// ----- hdl/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: front decoder, command queue
// and ring-store back end. Depends on deq_pkg, deq_in_if, deq_out_if and submodules.
`timescale 1ns / 1ps

// Usage:
// The cmd channel takes one transaction per operation: operation selects push
// front, push back, pop front, pop back, peek front or peek back, and value
// carries the word to push. Codes 6 and 7 do nothing but still give a result.
// The res channel returns exactly one transaction per request, in order, with
// the popped or peeked word, a status (ok, empty, or full with the push
// dropped), the element count after the operation and an empty flag.
// A request taken on cmd passes the decode register, the command queue, the execute
// stage and the output register to res. One operation per cycle is sustained
// unless res stalls; the ring store has one write and one registered read port.
// A two-entry queue separates decoding from execution, so a stall on res fills
// the output register, then the execute stage, the queue and the decode
// register, and only then drops cmd.ready; no transaction is lost. After reset
// the deque is empty with the front index at zero; the store contents are not
// cleared, and a word from an unwritten entry is never returned on res.
module double_ended_queue_unit #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_in_if.sink    cmd,
	deq_out_if.source res
);
	import deq_pkg::*;

	logic                  f_valid;
	deq_ctl_t              f_ctl;
	logic [DATA_WIDTH-1:0] f_word;
	logic                  f_ready;
	logic                  b_valid;
	deq_ctl_t              b_ctl;
	logic [DATA_WIDTH-1:0] b_word;
	logic                  b_ready;

	// Decode incoming requests.
	deq_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (f_valid),
		.q_ctl   (f_ctl),
		.q_word  (f_word),
		.q_ready (f_ready)
	);

	// Decouple decoding from execution.
	deq_fifo #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ctl   (f_ctl),
		.wr_word  (f_word),
		.wr_ready (f_ready),
		.rd_valid (b_valid),
		.rd_ctl   (b_ctl),
		.rd_word  (b_word),
		.rd_ready (b_ready)
	);

	// Execute against the ring store.
	deq_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (b_valid),
		.q_ctl   (b_ctl),
		.q_word  (b_word),
		.q_ready (b_ready),
		.res     (res)
	);

endmodule
